### design/lats_pkg.sv
package lats_pkg;

	// Field widths of the command and result items
	localparam int KIND_W = 2;
	localparam int IDX_W  = 6;

	// Default grid edge length (cells per row and rows per grid)
	localparam int GRID_SIZE_DEF = 64;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

	// Neighbor counts of the life rule
	localparam logic [3:0] NBR_KEEP  = 4'd2;
	localparam logic [3:0] NBR_BIRTH = 4'd3;

endpackage

### design/lats_in_if.sv
interface lats_in_if import lats_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  row;
	logic [IDX_W-1:0]  column;
	logic              write_value;

	modport source (output valid, output kind, output row, output column,
		output write_value, input ready);
	modport sink (input valid, input kind, input row, input column,
		input write_value, output ready);

endinterface

### design/lats_out_if.sv
interface lats_out_if import lats_pkg::*; ();

	logic valid;
	logic ready;
	logic read_value;
	logic generation_done;

	modport source (output valid, output read_value, output generation_done, input ready);
	modport sink (input valid, input read_value, input generation_done, output ready);

endinterface

### design/life_automaton_torus_step_top.sv
// Channel | Dir | Payload                              | Transfer
// cmd     | in  | kind, row, column, write_value       | valid && ready
// res     | out | read_value, generation_done          | valid && ready
//
// One item at a time; cmd.ready is high only while the sequencer is idle.
// Cell write or read: row read from idle, then the write-back or bit pick in the cell state, then finish.
// Unused kind or index off the grid: straight from idle to finish.
// Advance: reads of the last row and row 0, then one new row per cycle over the row memory's read and write ports.
// Reset clears the per-row valid flags, so every row reads dead with no clearing pass.
// A result waiting in the output register stalls only the finish of the next item.
module life_automaton_torus_step_top import lats_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lats_in_if.sink    cmd,
	lats_out_if.source res
);

	localparam int AW = $clog2(GRID_SIZE);
	localparam logic [AW-1:0] LAST = AW'(GRID_SIZE - 1);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_CELL_WR   = 3'd1;
	localparam logic [2:0] ST_CELL_RD   = 3'd2;
	localparam logic [2:0] ST_ADV_LAST  = 3'd3;
	localparam logic [2:0] ST_ADV_FIRST = 3'd4;
	localparam logic [2:0] ST_ADV_SWEEP = 3'd5;
	localparam logic [2:0] ST_FINISH    = 3'd6;

	logic [2:0]           state_q, state_nxt;
	logic [AW-1:0]        cnt_q;
	logic [GRID_SIZE-1:0] row_valid_q;
	logic                 rvalid_s1;
	logic                 out_valid_q;

	// Row memory and its read register
	logic [GRID_SIZE-1:0] mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] rdata_s1;

	// Sliding three-row window and the saved old row 0
	logic [GRID_SIZE-1:0] prev_q, mid_q, first_q;

	// Captured command fields and pending result
	logic [AW-1:0] row_q, col_q;
	logic          wv_q;
	logic          res_rd_q, res_done_q;
	logic          read_value_q, generation_done_q;

	logic                 cmd_fire, on_grid, load_out;
	logic                 mem_re, mem_we;
	logic [AW-1:0]        raddr, waddr;
	logic [GRID_SIZE-1:0] wdata, row_old, below, next_row;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign on_grid   = ({1'b0, cmd.row} < (IDX_W + 1)'(GRID_SIZE))
		&& ({1'b0, cmd.column} < (IDX_W + 1)'(GRID_SIZE));

	// Rows never written since reset read as dead
	assign row_old = rvalid_s1 ? rdata_s1 : '0;
	assign below   = (cnt_q == LAST) ? first_q : row_old;

	// Life rule on every column, neighbors wrapped at the row ends
	for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
		localparam int L = (c == 0) ? GRID_SIZE - 1 : c - 1;
		localparam int R = (c == GRID_SIZE - 1) ? 0 : c + 1;
		logic [3:0] n;
		assign n = 4'(prev_q[L]) + 4'(prev_q[c]) + 4'(prev_q[R])
			+ 4'(mid_q[L]) + 4'(mid_q[R])
			+ 4'(below[L]) + 4'(below[c]) + 4'(below[R]);
		assign next_row[c] = mid_q[c] ? (n == NBR_KEEP || n == NBR_BIRTH) : (n == NBR_BIRTH);
	end

	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || res.ready);

	// Sequencer and memory port control
	always_comb begin
		state_nxt = state_q;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		raddr     = '0;
		waddr     = '0;
		wdata     = row_old;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					unique case (cmd.kind)
						KIND_WRITE: begin
							if (on_grid) begin
								mem_re    = 1'b1;
								raddr     = cmd.row[AW-1:0];
								state_nxt = ST_CELL_WR;
							end else begin
								state_nxt = ST_FINISH;
							end
						end
						KIND_READ: begin
							if (on_grid) begin
								mem_re    = 1'b1;
								raddr     = cmd.row[AW-1:0];
								state_nxt = ST_CELL_RD;
							end else begin
								state_nxt = ST_FINISH;
							end
						end
						KIND_ADVANCE: begin
							mem_re    = 1'b1;
							raddr     = LAST;
							state_nxt = ST_ADV_LAST;
						end
						default: state_nxt = ST_FINISH;
					endcase
				end
			end
			ST_CELL_WR: begin
				mem_we       = 1'b1;
				waddr        = row_q;
				wdata[col_q] = wv_q;
				state_nxt    = ST_FINISH;
			end
			ST_CELL_RD: state_nxt = ST_FINISH;
			ST_ADV_LAST: begin
				mem_re    = 1'b1;
				raddr     = '0;
				state_nxt = ST_ADV_FIRST;
			end
			ST_ADV_FIRST: begin
				mem_re    = 1'b1;
				raddr     = AW'(1);
				state_nxt = ST_ADV_SWEEP;
			end
			ST_ADV_SWEEP: begin
				// read two rows ahead while the current new row goes back
				mem_re = (cnt_q < LAST - AW'(1));
				raddr  = cnt_q + AW'(2);
				mem_we = 1'b1;
				waddr  = cnt_q;
				wdata  = next_row;
				if (cnt_q == LAST) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			row_valid_q <= '0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (mem_re) begin
				rvalid_s1 <= row_valid_q[raddr];
			end
			if (mem_we) begin
				row_valid_q[waddr] <= 1'b1;
			end
			if (state_q == ST_ADV_FIRST) begin
				cnt_q <= '0;
			end else if (state_q == ST_ADV_SWEEP) begin
				cnt_q <= cnt_q + AW'(1);
			end
			out_valid_q <= load_out || (out_valid_q && !res.ready);
		end
	end

	// Row memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Window, captured fields and result payload
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			row_q      <= cmd.row[AW-1:0];
			col_q      <= cmd.column[AW-1:0];
			wv_q       <= cmd.write_value;
			res_rd_q   <= 1'b0;
			res_done_q <= 1'b0;
		end
		if (state_q == ST_CELL_RD) begin
			res_rd_q <= row_old[col_q];
		end
		if (state_q == ST_ADV_LAST) begin
			prev_q <= row_old;
		end
		if (state_q == ST_ADV_FIRST) begin
			mid_q   <= row_old;
			first_q <= row_old;
		end
		if (state_q == ST_ADV_SWEEP) begin
			prev_q <= mid_q;
			mid_q  <= below;
			if (cnt_q == LAST) begin
				res_done_q <= 1'b1;
			end
		end
		if (load_out) begin
			read_value_q      <= res_rd_q;
			generation_done_q <= res_done_q;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.read_value      = read_value_q;
	assign res.generation_done = generation_done_q;

endmodule
